@@ sv/glyph_cache_lru_policy_macros.svh @@
// ----------------------------------------------------------------------------
// Glyph cache LRU policy assertion macros
// Shared assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef GLYPH_CACHE_LRU_POLICY_MACROS_SVH
`define GLYPH_CACHE_LRU_POLICY_MACROS_SVH

// same-cycle implication
`define GLRU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GLRU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/glru_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph cache LRU policy package
// Sizes, payload structs and shared helpers for the glyph cache controller.
// ----------------------------------------------------------------------------
package glru_pkg;

    localparam int CACHE_ENTRIES = 16;
    localparam int SLOT_W        = $clog2(CACHE_ENTRIES);
    localparam int CNT_W         = $clog2(CACHE_ENTRIES + 1);
    localparam int BYTES_W       = 13;
    localparam int BYTE_PAD      = 7;
    localparam int PIX_PER_BYTE  = 8;
    localparam int PIX_SHIFT     = $clog2(PIX_PER_BYTE);
    localparam logic [BYTES_W-1:0] MAX_BYTES_RESET = 13'd24;

    typedef struct packed {
        logic [31:0] data_offset;
        logic [7:0]  glyph_width;
        logic [7:0]  glyph_height;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic               bypass;
        logic [3:0]         slot;
        logic [BYTES_W-1:0] bitmap_bytes;
        logic [31:0]        hit_total;
        logic [31:0]        miss_total;
        logic [4:0]         live_entries;
    } rsp_t;

    // running scan result handed from cell to cell
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] hit_idx;
        logic              inv;
        logic              have;
        logic [SLOT_W-1:0] vic_idx;
        logic [31:0]       vic_stamp;
        logic [CNT_W-1:0]  live;
    } carry_t;

    typedef struct packed {
        logic              en;
        logic              set_tag;
        logic [SLOT_W-1:0] idx;
        logic [31:0]       tag;
        logic [31:0]       stamp;
    } slot_wr_t;

    localparam carry_t CARRY_INIT = '{
        hit: 1'b0, hit_idx: '0, inv: 1'b0, have: 1'b0,
        vic_idx: '0, vic_stamp: '0, live: '0
    };

    function automatic logic [BYTES_W-1:0] calc_bytes(input logic [7:0] w,
                                                       input logic [7:0] h);
        logic [8:0]  padded;
        logic [5:0]  cols;
        logic [13:0] prod;
        padded = 9'(w) + 9'(BYTE_PAD);
        cols   = 6'(padded >> PIX_SHIFT);
        prod   = 14'(cols) * 14'(h);
        return BYTES_W'(prod);
    endfunction

endpackage

@@ sv/glru_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph cache slot cell
// Holds one slot's tag, valid bit and stamp; folds them into the scan carry.
// ----------------------------------------------------------------------------
module glru_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [glru_pkg::SLOT_W-1:0] idx,
    input  logic [31:0]            lookup_tag,
    input  glru_pkg::carry_t       carry_in,
    output glru_pkg::carry_t       carry_out,
    input  glru_pkg::slot_wr_t     wr
);
    import glru_pkg::*;

    logic        valid_reg;
    logic [31:0] tag_reg;
    logic [31:0] stamp_reg;
    carry_t      carry_next;
    carry_t      carry_reg;
    logic        wr_sel;

    assign wr_sel = wr.en && (wr.idx == idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr_sel && wr.set_tag)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_sel)
        begin
            stamp_reg <= wr.stamp;
            if (wr.set_tag)
            begin
                tag_reg <= wr.tag;
            end
        end
    end

    always_comb
    begin
        carry_next = carry_in;
        if (!carry_in.hit && valid_reg && (tag_reg == lookup_tag))
        begin
            carry_next.hit     = 1'b1;
            carry_next.hit_idx = idx;
        end
        if (!carry_in.inv)
        begin
            if (!valid_reg)
            begin
                carry_next.inv     = 1'b1;
                carry_next.vic_idx = idx;
            end
            else if (!carry_in.have || (stamp_reg < carry_in.vic_stamp))
            begin
                carry_next.have      = 1'b1;
                carry_next.vic_idx   = idx;
                carry_next.vic_stamp = stamp_reg;
            end
        end
        carry_next.live = carry_in.live + CNT_W'(valid_reg);
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
    end

    assign carry_out = carry_reg;

endmodule

@@ sv/glru_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph cache controller
// Request capture, scan sequencing, hit/miss/bypass decision and counters.
// ----------------------------------------------------------------------------
module glru_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  glru_pkg::req_t            req,
    output logic                      done,
    output glru_pkg::rsp_t            rsp,
    input  logic                      cfg_valid,
    input  logic [glru_pkg::BYTES_W-1:0] cfg_data,
    output logic [31:0]               lookup_tag,
    input  glru_pkg::carry_t          scan_result,
    output glru_pkg::slot_wr_t        wr
);
    import glru_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CACHE_ENTRIES - 1);

    state_t             state_reg, state_next;
    logic [SLOT_W-1:0]  scan_cnt_reg;
    req_t               req_reg;
    logic [BYTES_W-1:0] max_bytes_reg;
    logic [31:0]        use_cnt_reg;
    logic [31:0]        hit_cnt_reg;
    logic [31:0]        miss_cnt_reg;
    logic               done_reg;
    rsp_t               rsp_reg;

    logic [BYTES_W-1:0] bytes;
    logic               is_hit;
    logic               is_bypass;
    logic               install;
    logic [SLOT_W-1:0]  sel_idx;
    logic [CNT_W-1:0]   live_after;
    logic               accept;

    assign accept     = start && (state_reg == S_IDLE);
    assign busy       = (state_reg != S_IDLE);
    assign lookup_tag = req_reg.data_offset;

    assign bytes      = calc_bytes(req_reg.glyph_width, req_reg.glyph_height);
    assign is_hit     = scan_result.hit;
    assign is_bypass  = !is_hit && (bytes > max_bytes_reg);
    assign install    = !is_hit && !is_bypass;
    assign sel_idx    = is_hit ? scan_result.hit_idx : scan_result.vic_idx;
    assign live_after = scan_result.live + CNT_W'(install && scan_result.inv);

    always_comb
    begin
        wr.en      = (state_reg == S_DONE) && (is_hit || install);
        wr.set_tag = install;
        wr.idx     = sel_idx;
        wr.tag     = req_reg.data_offset;
        wr.stamp   = use_cnt_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_cnt_reg == LAST_SLOT)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_cnt_reg  <= '0;
            max_bytes_reg <= MAX_BYTES_RESET;
            use_cnt_reg   <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_DONE);
            if (cfg_valid)
            begin
                max_bytes_reg <= cfg_data;
            end
            if (state_reg == S_SCAN)
            begin
                scan_cnt_reg <= scan_cnt_reg + SLOT_W'(1);
            end
            else
            begin
                scan_cnt_reg <= '0;
            end
            if (wr.en)
            begin
                use_cnt_reg <= use_cnt_reg + 32'd1;
            end
            if ((state_reg == S_DONE) && is_hit)
            begin
                hit_cnt_reg <= hit_cnt_reg + 32'd1;
            end
            if ((state_reg == S_DONE) && install)
            begin
                miss_cnt_reg <= miss_cnt_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (state_reg == S_DONE)
        begin
            rsp_reg.hit          <= is_hit;
            rsp_reg.bypass       <= is_bypass;
            rsp_reg.slot         <= is_bypass ? 4'd0 : 4'(sel_idx);
            rsp_reg.bitmap_bytes <= bytes;
            rsp_reg.hit_total    <= hit_cnt_reg + 32'(is_hit);
            rsp_reg.miss_total   <= miss_cnt_reg + 32'(install);
            rsp_reg.live_entries <= 5'(live_after);
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

@@ sv/glyph_cache_lru_policy.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph cache LRU policy
// Tag lookup and LRU replacement for a fully associative glyph bitmap cache.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its lookup runs down
// a chain of CACHE_ENTRIES registered slot cells, one cell per cycle; busy stays
// high through the scan and the decision state S_DONE, and the response is
// registered at the end of S_DONE. The result is shown for exactly one cycle
// with done high and there is no way to hold it: capture rsp whenever done is
// seen. A new start is taken in the cycle done is high. The size limit is
// written through cfg_valid/cfg_data; cfg_ready is always high and the limit
// should only be changed while busy is low.
module glyph_cache_lru_policy (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  glru_pkg::req_t            req,
    output logic                      done,
    output glru_pkg::rsp_t            rsp,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [glru_pkg::BYTES_W-1:0] cfg_data
);
    import glru_pkg::*;

    carry_t      carry_chain [CACHE_ENTRIES+1];
    slot_wr_t    wr;
    logic [31:0] lookup_tag;

    assign cfg_ready      = 1'b1;
    assign carry_chain[0] = CARRY_INIT;

    glru_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .done        (done),
        .rsp         (rsp),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .lookup_tag  (lookup_tag),
        .scan_result (carry_chain[CACHE_ENTRIES]),
        .wr          (wr)
    );

    for (genvar i = 0; i < CACHE_ENTRIES; i++)
    begin : g_cell
        glru_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .idx        (SLOT_W'(i)),
            .lookup_tag (lookup_tag),
            .carry_in   (carry_chain[i]),
            .carry_out  (carry_chain[i+1]),
            .wr         (wr)
        );
    end

endmodule

@@ sv/glru_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph cache LRU policy checker
// Port-level checks on transaction sequencing and result consistency.
// ----------------------------------------------------------------------------
`include "glyph_cache_lru_policy_macros.svh"

module glru_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           busy,
    input  logic           done,
    input  glru_pkg::rsp_t rsp
);
    import glru_pkg::*;

    `GLRU_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
    `GLRU_ASSERT_NOW(a_done_after_busy, done, $past(busy) && !busy, "done without a transaction")
    `GLRU_ASSERT_NEXT(a_done_pulse, done, !done, "done held over two cycles")
    `GLRU_ASSERT_NOW(a_hit_bypass, done && rsp.bypass, !rsp.hit && (rsp.slot == 4'd0), "bad bypass")
    `GLRU_ASSERT_NOW(a_live_max, done, rsp.live_entries <= 5'(CACHE_ENTRIES), "live count too big")

endmodule

bind glyph_cache_lru_policy glru_checker u_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph cache LRU policy testbench
// Drives lookup requests through the start/busy port and checks every done
// response against a cycle-free LRU cache mirror, or against the golden response
// of a directed row that carries one. A short directed table runs first, then
// six random phases that sweep the size limit and sender idling.
module tb_top;
    import glru_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 40;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 100;
    localparam int TAG_POOL      = 24;
    localparam int REPORT_MAX    = 10;

    typedef struct {
        bit   has;
        rsp_t rsp;
    } golden_t;

    typedef struct {
        req_t    req;
        golden_t gold;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    req_t                req;
    logic                done;
    rsp_t                rsp;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [BYTES_W-1:0]  cfg_data;

    glyph_cache_lru_policy DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // cache mirror
    logic [31:0]        mirror_tag   [CACHE_ENTRIES];
    bit                 mirror_valid [CACHE_ENTRIES];
    logic [31:0]        mirror_stamp [CACHE_ENTRIES];
    logic [31:0]        mirror_use;
    logic [31:0]        mirror_hits;
    logic [31:0]        mirror_misses;
    logic [BYTES_W-1:0] mirror_limit;

    rsp_t    expected_rsp_q[$];
    golden_t typed_rsp_q[$];
    logic [31:0] tag_pool [TAG_POOL];

    int mismatch_cnt;
    int stall_cycles;
    int req_cnt;
    int hit_cnt;
    int miss_cnt;
    int bypass_cnt;
    int limit_writes;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic rsp_t predict_lookup(input req_t r);
        rsp_t        o;
        int          found;
        int          victim;
        int          live;
        int unsigned wpix;
        int unsigned hpix;
        int unsigned nbytes;
        wpix   = r.glyph_width;
        hpix   = r.glyph_height;
        nbytes = ((wpix + 7) / 8) * hpix;
        found  = -1;
        for (int i = 0; i < CACHE_ENTRIES; i++)
            if (found < 0 && mirror_valid[i] && mirror_tag[i] == r.data_offset)
                found = i;
        o = '0;
        o.bitmap_bytes = BYTES_W'(nbytes);
        if (found >= 0)
        begin
            mirror_stamp[found] = mirror_use;
            mirror_use  = mirror_use + 1;
            mirror_hits = mirror_hits + 1;
            o.hit  = 1'b1;
            o.slot = 4'(found);
        end
        else if (nbytes > mirror_limit)
        begin
            o.bypass = 1'b1;
        end
        else
        begin
            victim = -1;
            for (int i = 0; i < CACHE_ENTRIES; i++)
                if (victim < 0 && !mirror_valid[i])
                    victim = i;
            if (victim < 0)
            begin
                victim = 0;
                for (int i = 1; i < CACHE_ENTRIES; i++)
                    if (mirror_stamp[i] < mirror_stamp[victim])
                        victim = i;
            end
            mirror_tag[victim]   = r.data_offset;
            mirror_valid[victim] = 1'b1;
            mirror_stamp[victim] = mirror_use;
            mirror_use    = mirror_use + 1;
            mirror_misses = mirror_misses + 1;
            o.slot = 4'(victim);
        end
        live = 0;
        for (int i = 0; i < CACHE_ENTRIES; i++)
            if (mirror_valid[i])
                live++;
        o.hit_total    = mirror_hits;
        o.miss_total   = mirror_misses;
        o.live_entries = 5'(live);
        return o;
    endfunction

    function automatic string fmt_rsp(input rsp_t r);
        return $sformatf("hit=%0b bypass=%0b slot=%0d bytes=%0d hits=%0d misses=%0d live=%0d",
                         r.hit, r.bypass, r.slot, r.bitmap_bytes, r.hit_total,
                         r.miss_total, r.live_entries);
    endfunction

    // response check, then request capture, then limit write
    always @(posedge clk)
    begin : monitor
        rsp_t    want;
        rsp_t    predicted;
        golden_t gold;
        bit      moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (done)
            begin
                moved = 1'b1;
                if (expected_rsp_q.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX)
                        $display("ERROR: unexpected response %s", fmt_rsp(rsp));
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp.hit !== want.hit || rsp.bypass !== want.bypass ||
                        rsp.slot !== want.slot || rsp.bitmap_bytes !== want.bitmap_bytes ||
                        rsp.hit_total !== want.hit_total ||
                        rsp.miss_total !== want.miss_total ||
                        rsp.live_entries !== want.live_entries)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= REPORT_MAX)
                            $display("ERROR: response mismatch\n  exp %s\n  got %s",
                                     fmt_rsp(want), fmt_rsp(rsp));
                    end
                end
            end
            if (start && !busy)
            begin
                moved = 1'b1;
                predicted = predict_lookup(req);
                req_cnt++;
                if (predicted.hit)
                    hit_cnt++;
                else if (predicted.bypass)
                    bypass_cnt++;
                else
                    miss_cnt++;
                gold.has = 1'b0;
                gold.rsp = '0;
                if (typed_rsp_q.size() != 0)
                    gold = typed_rsp_q.pop_front();
                expected_rsp_q.push_back(gold.has ? gold.rsp : predicted);
            end
            if (cfg_valid && cfg_ready)
            begin
                moved = 1'b1;
                mirror_limit = cfg_data;
                limit_writes++;
            end
            stall_cycles <= moved ? 0 : stall_cycles + 1;
        end
    end

    initial
    begin : watchdog
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("glyph_cache_lru_policy test failed");
        $finish;
    end

    task automatic send_req(input req_t r, input bit has, input rsp_t gold_rsp,
                            input int idle_pct);
        golden_t g;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            req   <= req_t'({$urandom, 16'($urandom)});
            @(posedge clk);
        end
        g.has = has;
        g.rsp = gold_rsp;
        typed_rsp_q.push_back(g);
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [BYTES_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic req_t make_req();
        req_t r;
        int   sel;
        sel = $urandom_range(99);
        r.data_offset = (sel < 80) ? tag_pool[$urandom_range(TAG_POOL - 1)] : $urandom;
        sel = $urandom_range(99);
        if (sel < 10)
        begin
            r.glyph_width  = $urandom_range(1) ? 8'd0 : 8'($urandom);
            r.glyph_height = (r.glyph_width == 8'd0) ? 8'($urandom) : 8'd0;
        end
        else if (sel < 65)
        begin
            r.glyph_width  = 8'($urandom_range(40));
            r.glyph_height = 8'($urandom_range(12));
        end
        else
        begin
            r.glyph_width  = 8'($urandom);
            r.glyph_height = 8'($urandom);
        end
        return r;
    endfunction

    function automatic dir_row_t row(input logic [31:0] tag, input logic [7:0] w,
                                     input logic [7:0] h, input bit has, input bit hit,
                                     input bit byp, input int slot, input int nbytes,
                                     input int hits, input int misses, input int live);
        dir_row_t d;
        d.req.data_offset  = tag;
        d.req.glyph_width  = w;
        d.req.glyph_height = h;
        d.gold.has = has;
        d.gold.rsp = '{hit: hit, bypass: byp, slot: 4'(slot), bitmap_bytes: BYTES_W'(nbytes),
                       hit_total: 32'(hits), miss_total: 32'(misses),
                       live_entries: 5'(live)};
        return d;
    endfunction

    initial
    begin : main
        dir_row_t           dir_rows[$];
        logic [BYTES_W-1:0] limits[PHASES];
        int                 idle_pct[PHASES];
        rst_n        = 1'b0;
        start        = 1'b0;
        req          = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        stall_cycles = 0;
        mismatch_cnt = 0;
        req_cnt      = 0;
        hit_cnt      = 0;
        miss_cnt     = 0;
        bypass_cnt   = 0;
        limit_writes = 0;
        for (int i = 0; i < CACHE_ENTRIES; i++)
        begin
            mirror_tag[i]   = '0;
            mirror_valid[i] = 1'b0;
            mirror_stamp[i] = '0;
        end
        mirror_use    = '0;
        mirror_hits   = '0;
        mirror_misses = '0;
        mirror_limit  = MAX_BYTES_RESET;

        limits   = '{13'd8160, 13'd0, 13'd24, 13'($urandom_range(1, 8159)),
                     13'd8160, 13'($urandom_range(1, 8159))};
        idle_pct = '{9, 9, 85, 85, 0, 0};

        // reset limit is 24; tag zero is a real tag
        dir_rows.push_back(row(32'h0000_0000, 8'd0,   8'd0,   1, 0, 0, 0, 0,    0, 1, 1));
        dir_rows.push_back(row(32'h0000_0000, 8'd8,   8'd3,   1, 1, 0, 0, 3,    1, 1, 1));
        dir_rows.push_back(row(32'hFFFF_FFFF, 8'd255, 8'd255, 1, 0, 1, 0, 8160, 1, 1, 1));
        dir_rows.push_back(row(32'h0000_0001, 8'd9,   8'd12,  1, 0, 0, 1, 24,   1, 2, 2));
        dir_rows.push_back(row(32'h0000_0002, 8'd1,   8'd25,  1, 0, 1, 0, 25,   1, 2, 2));
        // hit wins over the size limit
        dir_rows.push_back(row(32'h0000_0000, 8'd255, 8'd255, 1, 1, 0, 0, 8160, 2, 2, 2));
        for (int t = 3; t <= 16; t++)
            dir_rows.push_back(row(32'(t), 8'(t), 8'd1, 0, 0, 0, 0, 0, 0, 0, 0));
        // full cache: evictions by oldest stamp
        dir_rows.push_back(row(32'd100, 8'd7, 8'd2, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(32'd1,   8'd2, 8'd2, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(32'h5555_AAAA, 8'd0, 8'd255, 0, 0, 0, 0, 0, 0, 0, 0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_req(dir_rows[i].req, dir_rows[i].gold.has, dir_rows[i].gold.rsp, 0);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            write_limit(limits[p]);
            tag_pool[0] = 32'h0000_0000;
            tag_pool[1] = 32'hFFFF_FFFF;
            for (int i = 2; i < TAG_POOL; i++)
                tag_pool[i] = $urandom;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k == PHASE_ITEMS / 2)
                    drain();
                send_req(make_req(), 1'b0, '0, idle_pct[p]);
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        mismatch_cnt += expected_rsp_q.size();

        $display("Summary: %0d lookups, %0d hits, %0d cached misses, %0d bypasses",
                 req_cnt, hit_cnt, miss_cnt, bypass_cnt);
        $display("Summary: %0d size limit writes incl. 0 and 8160, %0d mismatches",
                 limit_writes, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("glyph_cache_lru_policy test passed");
        else
            $display("glyph_cache_lru_policy test failed");
        $finish;
    end

endmodule
